[sv/ovn_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the octave value noise unit.
// No dependencies; imported by every module of the block.
package ovn_pkg;

  // Field and datapath widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned ZOOM_W   = 24;
  localparam int unsigned PERS_W   = 17;
  localparam int unsigned OCT_W    = 4;
  localparam int unsigned BASE_W   = COORD_W + ZOOM_W;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned AMP_W    = 32;
  localparam int unsigned NOCT_W   = 5;
  localparam int unsigned VAL_W    = 18;
  localparam int unsigned WGT_W    = 17;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned CELL_STAGES = 8;

  // Defaults for top-level parameters
  localparam int unsigned MAX_OCTAVES_DEF    = 8;
  localparam int unsigned COS_TABLE_SIZE_DEF = 1024;

  // Register map
  localparam logic [1:0] REG_INV_ZOOM    = 2'd0;
  localparam logic [1:0] REG_PERSISTENCE = 2'd1;
  localparam logic [1:0] REG_OCTAVE_CNT  = 2'd2;

  localparam logic [ZOOM_W-1:0] INV_ZOOM_RST    = 24'd65536;
  localparam logic [PERS_W-1:0] PERSISTENCE_RST = 17'd32768;
  localparam logic [OCT_W-1:0]  OCTAVE_CNT_RST  = 4'd4;

  // Hash constants
  localparam logic [HASH_W-1:0] HASH_MUL  = 32'd60493;
  localparam logic [HASH_W-1:0] HASH_ADD1 = 32'd19990303;
  localparam logic [HASH_W-1:0] HASH_ADD2 = 32'd1376312589;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7fffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sh800000;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  // Item carried from cell to cell
  typedef struct packed {
    logic [BASE_W-1:0]       bx;
    logic [BASE_W-1:0]       by;
    logic signed [SUM_W-1:0] sum;
    logic [AMP_W-1:0]        amp;
    logic [NOCT_W-1:0]       noct;
  } ovn_item_t;

  // Half-period cosine weight in Q0.16, Taylor series in Q30
  function automatic longint unsigned half_weight(longint unsigned j, int unsigned lg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned f;
    x  = (PI_Q30 * j) >> lg;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 90;
    t  = Q30_ONE - ((x2 * t) >> 30) / 56;
    t  = Q30_ONE - ((x2 * t) >> 30) / 30;
    t  = Q30_ONE - ((x2 * t) >> 30) / 12;
    f  = ((x2 * t) >> 30) >> 2;
    return (f + 64'd8192) >> 14;
  endfunction

  // ROM entry i of a table of 2^lg entries
  function automatic logic [WGT_W-1:0] cos_weight(int unsigned i, int unsigned lg);
    longint unsigned n;
    longint unsigned r;
    n = 64'd1 << lg;
    if (2 * longint'(i) > n) begin
      r = 64'd65536 - half_weight(n - longint'(i), lg);
    end else begin
      r = half_weight(longint'(i), lg);
    end
    return r[WGT_W-1:0];
  endfunction

  // floor((a*(65536-w) + b*w) / 65536)
  function automatic logic signed [VAL_W-1:0] blend(logic signed [VAL_W-1:0] a,
                                                    logic signed [VAL_W-1:0] b,
                                                    logic [WGT_W-1:0] w);
    logic signed [VAL_W:0]     wi;
    logic signed [VAL_W:0]     ws;
    logic signed [2*VAL_W+1:0] acc;
    ws  = signed'({2'b00, w});
    wi  = (VAL_W+1)'(65536) - ws;
    acc = (2*VAL_W+2)'(a * wi) + (2*VAL_W+2)'(b * ws);
    return VAL_W'(acc >>> 16);
  endfunction

endpackage

[sv/ovn_cos_rom.sv]
`timescale 1ns / 1ps
// Cosine interpolation weight table with a registered read port.
// Depends on ovn_pkg for the table entry function.
module ovn_cos_rom #(
  parameter int unsigned LOG2N = 10
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [LOG2N-1:0]         idx,
  output logic [ovn_pkg::WGT_W-1:0] data
);
  import ovn_pkg::*;

  localparam int unsigned DEPTH = 1 << LOG2N;

  logic [WGT_W-1:0] tbl [DEPTH];
  logic [WGT_W-1:0] data_r;

  // Fill the table with elaboration-time constants
  for (genvar i = 0; i < DEPTH; i++) begin : g_tbl
    localparam logic [WGT_W-1:0] ENTRY = cos_weight(i, LOG2N);
    assign tbl[i] = ENTRY;
  end

  // Register the looked-up weight
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= tbl[idx];
    end
  end

  assign data = data_r;
endmodule

[sv/ovn_cell.sv]
`timescale 1ns / 1ps
// One octave cell: hashes four lattice corners, blends them and adds the
// weighted term to the running sum. Depends on ovn_pkg and ovn_cos_rom.
module ovn_cell #(
  parameter int unsigned K     = 0,
  parameter int unsigned LOG2N = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [ovn_pkg::PERS_W-1:0] persistence,
  input  logic                       in_valid,
  input  ovn_pkg::ovn_item_t         in_item,
  output logic                       out_valid,
  output ovn_pkg::ovn_item_t         out_item
);
  import ovn_pkg::*;

  localparam int unsigned ST    = CELL_STAGES;
  localparam int unsigned XW    = BASE_W + 16;
  localparam int unsigned TERM_W = VAL_W + AMP_W + 1 - 16;
  localparam int unsigned PROD_W = VAL_W + AMP_W + 1;

  logic [ST-1:0]     v_r;
  ovn_item_t         it_r [ST];

  logic [XW-1:0]     xs;
  logic [XW-1:0]     ys;
  logic [HASH_W-1:0] ix;
  logic [HASH_W-1:0] iy;
  logic [HASH_W-1:0] n00;
  logic [HASH_W-1:0] n_a [4];
  logic [WGT_W-1:0]  wx_rom;
  logic [WGT_W-1:0]  wy_rom;

  logic [HASH_W-1:0] n_r [3][4];
  logic [HASH_W-1:0] sq_r [4];
  logic [HASH_W-1:0] h1_r [4];
  logic signed [VAL_W-1:0] val_r [4];
  logic [WGT_W-1:0]  wx_d_r [4];
  logic [WGT_W-1:0]  wy_d_r [4];
  logic signed [VAL_W-1:0] r0_r;
  logic signed [VAL_W-1:0] r1_r;
  logic signed [VAL_W-1:0] s_r;
  logic signed [TERM_W-1:0] term_r;
  logic [AMP_W-1:0]  amp_g_r;
  logic [AMP_W-1:0]  amp_h_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [TERM_W:0]  acc;
  logic              active;

  // Scale by 2^K and split into lattice index and fraction
  always_comb begin
    xs  = XW'(in_item.bx) << K;
    ys  = XW'(in_item.by) << K;
    ix  = xs[47:16];
    iy  = ys[47:16];
    n00 = ix + 32'((iy << 6) - (iy << 3) + iy);
    n_a[0] = n00;
    n_a[1] = n00 + 32'd1;
    n_a[2] = n00 + 32'd57;
    n_a[3] = n00 + 32'd58;
  end

  ovn_cos_rom #(.LOG2N(LOG2N)) u_rom_x (
    .clk(clk), .en(en), .idx(xs[15 -: LOG2N]), .data(wx_rom)
  );
  ovn_cos_rom #(.LOG2N(LOG2N)) u_rom_y (
    .clk(clk), .en(en), .idx(ys[15 -: LOG2N]), .data(wy_rom)
  );

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ST-2:0], in_valid};
    end
  end

  // Hash, blend and accumulate pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= in_item;
      for (int i = 1; i < ST; i++) begin
        it_r[i] <= it_r[i-1];
      end
      for (int c = 0; c < 4; c++) begin
        n_r[0][c] <= n_a[c] ^ (n_a[c] << 13);
        n_r[1][c] <= n_r[0][c];
        n_r[2][c] <= n_r[1][c];
        sq_r[c]   <= 32'(n_r[0][c] * n_r[0][c]);
        h1_r[c]   <= 32'(sq_r[c] * HASH_MUL) + HASH_ADD1;
        val_r[c]  <= VAL_W'(65536) - signed'({1'b0,
                     17'((32'(n_r[2][c] * h1_r[c]) + HASH_ADD2) >> 14)});
      end
      wx_d_r[0] <= wx_rom;
      wy_d_r[0] <= wy_rom;
      for (int i = 1; i < 4; i++) begin
        wx_d_r[i] <= wx_d_r[i-1];
        wy_d_r[i] <= wy_d_r[i-1];
      end
      r0_r    <= blend(val_r[0], val_r[1], wx_d_r[2]);
      r1_r    <= blend(val_r[2], val_r[3], wx_d_r[2]);
      s_r     <= blend(r0_r, r1_r, wy_d_r[3]);
      term_r  <= TERM_W'((PROD_W'(s_r) * signed'({1'b0, it_r[5].amp})) >>> 16);
      amp_g_r <= AMP_W'(((AMP_W + PERS_W)'(it_r[5].amp) * persistence) >> 16);
      amp_h_r <= amp_g_r;
      sum_r   <= sum_nxt;
    end
  end

  // Add the term when this octave is in use, saturate to the sum range
  always_comb begin
    active = (it_r[6].noct > NOCT_W'(K));
    acc    = (TERM_W+1)'(it_r[6].sum) + (active ? (TERM_W+1)'(term_r) : '0);
    if (acc > (TERM_W+1)'(SUM_MAX)) begin
      sum_nxt = SUM_MAX;
    end else if (acc < (TERM_W+1)'(SUM_MIN)) begin
      sum_nxt = SUM_MIN;
    end else begin
      sum_nxt = SUM_W'(acc);
    end
  end

  // Hand the item to the next cell
  always_comb begin
    out_item     = it_r[ST-1];
    out_item.sum = sum_r;
    out_item.amp = amp_h_r;
  end
  assign out_valid = v_r[ST-1];
endmodule

[sv/octave_value_noise_pixel_unit.sv]
`timescale 1ns / 1ps
// Octave value noise pixel unit: top level with register port and cell chain.
// Input register, then MAX_OCTAVES-1 octave cells (at least one), each 8
// stages deep, then the output register. Throughput one item per cycle, every stage
// advancing together unless the output register holds an item under stall.
// Reset clears valid bits and loads register defaults; no clearing pass.
module octave_value_noise_pixel_unit #(
  parameter int unsigned MAX_OCTAVES    = ovn_pkg::MAX_OCTAVES_DEF,
  parameter int unsigned COS_TABLE_SIZE = ovn_pkg::COS_TABLE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ovn_pkg::COORD_W-1:0] in_coord_x,
  input  logic [ovn_pkg::COORD_W-1:0] in_coord_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ovn_pkg::COLOR_W-1:0] out_color,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ovn_pkg::*;

  localparam int unsigned NCELL = (MAX_OCTAVES > 1) ? MAX_OCTAVES - 1 : 1;
  localparam int unsigned LOG2N = $clog2(COS_TABLE_SIZE);

  logic [ZOOM_W-1:0] inv_zoom_r;
  logic [PERS_W-1:0] persistence_r;
  logic [OCT_W-1:0]  octave_cnt_r;
  logic              wr_en;
  logic              en;
  logic [NOCT_W-1:0] cnt_c;
  logic [NOCT_W-1:0] noct;
  logic              v0_r;
  ovn_item_t         item0_r;
  logic              cv [NCELL+1];
  ovn_item_t         ci [NCELL+1];
  logic              out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [COLOR_W-1:0] color_nxt;
  logic signed [SUM_W-10:0] sh;
  logic signed [SUM_W-9:0]  vv;

  // Register writes
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_zoom_r    <= INV_ZOOM_RST;
      persistence_r <= PERSISTENCE_RST;
      octave_cnt_r  <= OCTAVE_CNT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_INV_ZOOM:    inv_zoom_r    <= pwdata[ZOOM_W-1:0];
        REG_PERSISTENCE: persistence_r <= pwdata[PERS_W-1:0];
        REG_OCTAVE_CNT:  octave_cnt_r  <= pwdata[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_INV_ZOOM:    prdata = 32'(inv_zoom_r);
      REG_PERSISTENCE: prdata = 32'(persistence_r);
      REG_OCTAVE_CNT:  prdata = 32'(octave_cnt_r);
      default:         prdata = '0;
    endcase
  end

  // Hold everything while the output register is stalled
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Limit the octave setting and derive the number of summed octaves
  always_comb begin
    cnt_c = (NOCT_W'(octave_cnt_r) > NOCT_W'(MAX_OCTAVES)) ?
            NOCT_W'(MAX_OCTAVES) : NOCT_W'(octave_cnt_r);
    noct  = (cnt_c >= NOCT_W'(2)) ? cnt_c - NOCT_W'(1) : '0;
  end

  // Input stage: scale coordinates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item0_r.bx   <= BASE_W'(in_coord_x) * BASE_W'(inv_zoom_r);
      item0_r.by   <= BASE_W'(in_coord_y) * BASE_W'(inv_zoom_r);
      item0_r.sum  <= '0;
      item0_r.amp  <= AMP_W'(65536);
      item0_r.noct <= noct;
    end
  end

  assign cv[0] = v0_r;
  assign ci[0] = item0_r;

  // Chain of octave cells
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ovn_cell #(.K(k), .LOG2N(LOG2N)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .persistence(persistence_r),
      .in_valid(cv[k]), .in_item(ci[k]),
      .out_valid(cv[k+1]), .out_item(ci[k+1])
    );
  end

  // Map the sum to a color and saturate
  always_comb begin
    sh = (SUM_W-9)'(ci[NCELL].sum >>> 9);
    vv = (SUM_W-8)'(sh) + (SUM_W-8)'(128);
    if (vv > (SUM_W-8)'(255)) begin
      color_nxt = 8'd255;
    end else if (vv < 0) begin
      color_nxt = 8'd0;
    end else begin
      color_nxt = COLOR_W'(vv);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_color_r <= color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_color = out_color_r;

  // Checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a stalled result");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && cv[NCELL]) |=> out_valid)
    else $error("item from last cell not shown at output");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && cv[NCELL]) |=> cv[NCELL])
    else $error("cell chain moved while stalled");
endmodule

[verif/octave_value_noise_pixel_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the octave value noise pixel unit: tracks register writes, predicts
// each item's color and compares results in order. Depends on ovn_pkg.
module octave_value_noise_pixel_unit_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [ovn_pkg::COORD_W-1:0] in_coord_x,
  input  logic [ovn_pkg::COORD_W-1:0] in_coord_y,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ovn_pkg::COLOR_W-1:0] out_color,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          errors,
  output int                          pending,
  output int                          colors_seen
);
  import ovn_pkg::*;

  localparam int unsigned TABLE_N = 1024;
  localparam int unsigned MAX_OCT = 8;

  logic [ZOOM_W-1:0]  zoom_q;
  logic [PERS_W-1:0]  pers_q;
  logic [OCT_W-1:0]   octs_q;
  longint             cos_rom [TABLE_N];
  logic [COLOR_W-1:0] color_fifo [$];

  // Half-period cosine weight, Taylor series in Q30, rounded to Q0.16
  function automatic longint half_cos(longint unsigned j);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned f;
    x  = (64'd3373259426 * j) / TABLE_N;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 90;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 56;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 30;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 12;
    f  = ((x2 * t) >> 30) >> 2;
    return longint'((f + 64'd8192) >> 14);
  endfunction

  // Hash a lattice corner into a signed Q.16 value
  function automatic longint corner_value(bit [31:0] ix, bit [31:0] iy);
    bit [31:0] n;
    bit [31:0] h;
    n = ix + iy * 32'd57;
    n = (n << 13) ^ n;
    h = n * n;
    h = h * 32'd60493 + 32'd19990303;
    h = n * h + 32'd1376312589;
    h[31] = 1'b0;
    return 64'sd65536 - longint'(h >> 14);
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return (a * (64'sd65536 - w) + b * w) >>> 16;
  endfunction

  function automatic longint octave_noise(longint unsigned px, longint unsigned py);
    bit [31:0] ix;
    bit [31:0] iy;
    longint    wx;
    longint    wy;
    longint    r0;
    longint    r1;
    ix = px[47:16];
    iy = py[47:16];
    wx = cos_rom[px[15:6]];
    wy = cos_rom[py[15:6]];
    r0 = mix(corner_value(ix, iy), corner_value(ix + 1, iy), wx);
    r1 = mix(corner_value(ix, iy + 1), corner_value(ix + 1, iy + 1), wx);
    return mix(r0, r1, wy);
  endfunction

  function automatic logic [COLOR_W-1:0] noise_color(logic [COORD_W-1:0] cx,
                                                     logic [COORD_W-1:0] cy);
    longint unsigned bx;
    longint unsigned by;
    longint          amp;
    longint          total;
    longint          v;
    int unsigned     octs;
    bx    = longint'(cx) * longint'(zoom_q);
    by    = longint'(cy) * longint'(zoom_q);
    amp   = 65536;
    total = 0;
    octs  = (octs_q > MAX_OCT) ? MAX_OCT : octs_q;
    for (int k = 0; k + 1 < int'(octs); k++) begin
      total += (octave_noise(bx << k, by << k) * amp) >>> 16;
      if (total > 64'sd8388607) total = 64'sd8388607;
      if (total < -64'sd8388608) total = -64'sd8388608;
      amp = (amp * longint'(pers_q)) >>> 16;
    end
    v = (total >>> 9) + 128;
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    return v[COLOR_W-1:0];
  endfunction

  // Build the weight table once
  initial begin
    for (int i = 0; i < TABLE_N; i++) begin
      if (2 * i > TABLE_N) cos_rom[i] = 65536 - half_cos(TABLE_N - i);
      else cos_rom[i] = half_cos(i);
    end
  end

  assign pending = color_fifo.size();

  // Track registers, predict accepted items, compare results
  always @(posedge clk) begin
    logic [COLOR_W-1:0] want;
    if (!rst_n) begin
      zoom_q <= INV_ZOOM_RST;
      pers_q <= PERSISTENCE_RST;
      octs_q <= OCTAVE_CNT_RST;
      errors      = 0;
      colors_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INV_ZOOM:    zoom_q <= pwdata[ZOOM_W-1:0];
          REG_PERSISTENCE: pers_q <= pwdata[PERS_W-1:0];
          REG_OCTAVE_CNT:  octs_q <= pwdata[OCT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) color_fifo.push_back(noise_color(in_coord_x, in_coord_y));
      if (out_valid && !out_stall) begin
        colors_seen++;
        if (color_fifo.size() == 0) begin
          errors++;
          $display("%0t: unexpected color item, expected none, actual %0d", $time, out_color);
        end else begin
          want = color_fifo.pop_front();
          if (want !== out_color) begin
            errors++;
            $display("%0t: color mismatch, expected %0d, actual %0d", $time, want, out_color);
          end
        end
      end
    end
  end

endmodule

[verif/octave_value_noise_pixel_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the octave value noise pixel unit: clock, reset, register
// writes and pixel stimulus. Depends on ovn_pkg, the unit and the checker module.
module octave_value_noise_pixel_unit_tb;
  import ovn_pkg::*;

  localparam int  DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 1000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [COORD_W-1:0] in_coord_x;
  logic [COORD_W-1:0] in_coord_y;
  logic               out_valid;
  logic               out_stall;
  logic [COLOR_W-1:0] out_color;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;
  int                 colors_seen;
  longint             cycles = 0;
  bit                 calm;
  int                 stall_left;
  int                 phases;

  octave_value_noise_pixel_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_color(out_color),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  octave_value_noise_pixel_unit_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_color(out_color),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .colors_seen(colors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= calm ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int gap;
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every expected color, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Empty the pipe before touching the registers
  task automatic configure(logic [31:0] zoom, logic [31:0] pers, logic [31:0] octs);
    drain();
    write_reg(REG_INV_ZOOM, zoom);
    write_reg(REG_PERSISTENCE, pers);
    write_reg(REG_OCTAVE_CNT, octs);
    phases++;
  endtask

  task automatic random_pixels(int count, bit narrow);
    for (int i = 0; i < count; i++) begin
      if (narrow) send_pixel($urandom_range(0, 255), $urandom_range(0, 255));
      else send_pixel($urandom, $urandom);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    calm       = 1'b1;
    phases     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, coordinate extremes
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hffff, 16'hffff);
    send_pixel(16'hffff, 16'h0000);
    send_pixel(16'h0000, 16'hffff);
    send_pixel(16'haaaa, 16'h5555);
    send_pixel(16'h5555, 16'haaaa);
    send_pixel(16'h0001, 16'h8000);
    drain();
    // Few octaves, zero zoom, large persistence, too many octaves
    configure(32'd65536, 32'd32768, 32'd0);
    send_pixel(16'h1234, 16'h4321);
    configure(32'd65536, 32'd32768, 32'd1);
    send_pixel(16'h1234, 16'h4321);
    configure(32'd0, 32'd32768, 32'd8);
    send_pixel(16'hffff, 16'h7777);
    configure(32'hffffffff, 32'hffffffff, 32'd15);
    send_pixel(16'hffff, 16'hffff);
    send_pixel(16'h0003, 16'h0100);
    configure(32'd1, 32'd0, 32'd9);
    send_pixel(16'hffff, 16'hffff);
    configure(32'd16777215, 32'd65536, 32'd2);
    send_pixel(16'h8001, 16'h0fff);
    send_pixel(16'h0000, 16'hffff);
    drain();

    // Random phases: extremes first, then random settings
    calm = 1'b0;
    configure(32'd4096, 32'd65536, 32'd8);
    random_pixels(150, 1'b1);
    drain();
    configure(32'd16777215, 32'd131071, 32'd8);
    random_pixels(150, 1'b0);
    drain();
    configure(32'd1, 32'd0, 32'd3);
    random_pixels(150, 1'b0);
    drain();
    for (int p = 0; p < 9; p++) begin
      calm = (p == 4);
      configure($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 131072),
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536),
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(2, 8));
      random_pixels(150, p[0]);
      drain();
    end

    $display("Covered %0d colors over %0d register settings in %0d cycles.",
             colors_seen, phases, cycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
sv/ovn_pkg.sv
sv/ovn_cos_rom.sv
sv/ovn_cell.sv
sv/octave_value_noise_pixel_unit.sv
verif/octave_value_noise_pixel_unit_checker.sv
verif/octave_value_noise_pixel_unit_tb.sv
